[rtl/light_diameter_shading_factor_top_defines.svh]
// assertion macros shared by the shading factor block
`ifndef LIGHT_DIAMETER_SHADING_FACTOR_TOP_DEFINES_SVH
`define LIGHT_DIAMETER_SHADING_FACTOR_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define LDSF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ldsf check failed");

// condition implies consequence in the next cycle
`define LDSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ldsf check failed");

`endif

[rtl/ldsf_pkg.sv]
// shared types, constants and root table function for the shading factor block
package ldsf_pkg;

	localparam int DIV_STAGES = 31;
	localparam int LOG_STAGES = 16;
	localparam int POW_STAGES = 16;

	localparam logic [14:0] SCALE_RESET = 15'd25600;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [39:0] POW_SAT = 40'h80_0000_0000;
	localparam logic [24:0] ONE_Q24 = 25'h100_0000;
	localparam logic [15:0] RESULT_ONE = 16'd32768;

	// side data carried through the divider
	typedef struct packed {
		logic [15:0] a;
		logic [31:0] t;
	} div_side_t;

	// side data carried through the log2 stages
	typedef struct packed {
		logic [15:0] a;
		logic [4:0]  p;
		logic        z;
		logic [10:0] n;
		logic        fz;
	} log_side_t;

	// side data carried through the exp2 stages
	typedef struct packed {
		logic [10:0] nn;
		logic        z;
		logic        a0;
		logic [10:0] n;
		logic        fz;
	} pow_side_t;

	localparam int DIV_SIDE_W = $bits(div_side_t);
	localparam int LOG_SIDE_W = $bits(log_side_t);
	localparam int POW_SIDE_W = $bits(pow_side_t);

	// bitwise integer square root
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] w;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		w = v;
		for (int i = 0; i < 32; i++) begin
			if (w >= r + b) begin
				w = w - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-i) in Q30 by repeated square roots
	function automatic logic [30:0] root_q30(input int i);
		logic [63:0] r;
		r = 64'h8000_0000;
		for (int j = 1; j <= i; j++) begin
			r = isqrt64(r << 30);
		end
		return r[30:0];
	endfunction

endpackage

[rtl/ldsf_div.sv]
// pipelined restoring divider, one quotient bit per stage
module ldsf_div
	import ldsf_pkg::*;
#(
	parameter int SIDE_W = DIV_SIDE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [14:0]       num,
	input  logic [14:0]       den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_v,
	output logic [30:0]       quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s    [DIV_STAGES];
	logic [14:0]       rem_s  [DIV_STAGES];
	logic [30:0]       q_s    [DIV_STAGES];
	logic [14:0]       num_s  [DIV_STAGES];
	logic [14:0]       den_s  [DIV_STAGES];
	logic [SIDE_W-1:0] side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic              pv;
		logic [14:0]       prem;
		logic [30:0]       pq;
		logic [14:0]       pnum;
		logic [14:0]       pden;
		logic [SIDE_W-1:0] pside;
		logic              nb;
		logic [15:0]       trial;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = '0;
			assign pq    = '0;
			assign pnum  = num;
			assign pden  = den;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign pq    = q_s[k-1];
			assign pnum  = num_s[k-1];
			assign pden  = den_s[k-1];
			assign pside = side_s[k-1];
		end

		// next dividend bit: numerator followed by sixteen zeros
		if (k < 15) begin : g_bit
			assign nb = pnum[14-k];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign trial = {prem, nb};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// trial subtract and quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, pden}) begin
					rem_s[k] <= 15'(trial - {1'b0, pden});
					q_s[k]   <= {pq[29:0], 1'b1};
				end else begin
					rem_s[k] <= trial[14:0];
					q_s[k]   <= {pq[29:0], 1'b0};
				end
				num_s[k]  <= pnum;
				den_s[k]  <= pden;
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[DIV_STAGES-1];
	assign quo      = q_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

[rtl/ldsf_log2.sv]
// log2 fraction bits by repeated squaring, one bit per stage
module ldsf_log2
	import ldsf_pkg::*;
#(
	parameter int SIDE_W = LOG_SIDE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [30:0]       mant,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_v,
	output logic [15:0]       frac,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s    [LOG_STAGES];
	logic [30:0]       m_s    [LOG_STAGES];
	logic [15:0]       fr_s   [LOG_STAGES];
	logic [SIDE_W-1:0] side_s [LOG_STAGES];

	for (genvar k = 0; k < LOG_STAGES; k++) begin : g_stage
		logic              pv;
		logic [30:0]       pm;
		logic [15:0]       pfr;
		logic [SIDE_W-1:0] pside;
		logic [61:0]       sq;
		logic [31:0]       sqs;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign pm    = mant;
			assign pfr   = '0;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pm    = m_s[k-1];
			assign pfr   = fr_s[k-1];
			assign pside = side_s[k-1];
		end

		// square in Q30, renormalize when it reaches two
		assign sq  = {31'b0, pm} * {31'b0, pm};
		assign sqs = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (sqs[31]) begin
					m_s[k]  <= sqs[31:1];
					fr_s[k] <= {pfr[14:0], 1'b1};
				end else begin
					m_s[k]  <= sqs[30:0];
					fr_s[k] <= {pfr[14:0], 1'b0};
				end
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[LOG_STAGES-1];
	assign frac     = fr_s[LOG_STAGES-1];
	assign side_out = side_s[LOG_STAGES-1];

endmodule

[rtl/ldsf_pow2.sv]
// two lanes of 2^frac in Q30 as a product of constant roots, one root per stage
module ldsf_pow2
	import ldsf_pkg::*;
#(
	parameter int SIDE_W = POW_SIDE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [15:0]       f0,
	input  logic [15:0]       f1,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_v,
	output logic [30:0]       m0,
	output logic [30:0]       m1,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s    [POW_STAGES];
	logic [30:0]       m0_s   [POW_STAGES];
	logic [30:0]       m1_s   [POW_STAGES];
	logic [15:0]       f0_s   [POW_STAGES];
	logic [15:0]       f1_s   [POW_STAGES];
	logic [SIDE_W-1:0] side_s [POW_STAGES];

	for (genvar k = 0; k < POW_STAGES; k++) begin : g_stage
		localparam logic [30:0] ROOT = root_q30(k + 1);
		logic              pv;
		logic [30:0]       pm0;
		logic [30:0]       pm1;
		logic [15:0]       pf0;
		logic [15:0]       pf1;
		logic [SIDE_W-1:0] pside;
		logic [61:0]       pr0;
		logic [61:0]       pr1;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign pm0   = 31'h4000_0000;
			assign pm1   = 31'h4000_0000;
			assign pf0   = f0;
			assign pf1   = f1;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pm0   = m0_s[k-1];
			assign pm1   = m1_s[k-1];
			assign pf0   = f0_s[k-1];
			assign pf1   = f1_s[k-1];
			assign pside = side_s[k-1];
		end

		assign pr0 = {31'b0, pm0} * {31'b0, ROOT};
		assign pr1 = {31'b0, pm1} * {31'b0, ROOT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// multiply in this root where its fraction bit is set
		always_ff @(posedge clk) begin
			if (en) begin
				m0_s[k]   <= pf0[15-k] ? pr0[60:30] : pm0;
				m1_s[k]   <= pf1[15-k] ? pr1[60:30] : pm1;
				f0_s[k]   <= pf0;
				f1_s[k]   <= pf1;
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[POW_STAGES-1];
	assign m0       = m0_s[POW_STAGES-1];
	assign m1       = m1_s[POW_STAGES-1];
	assign side_out = side_s[POW_STAGES-1];

endmodule

[rtl/light_diameter_shading_factor_top.sv]
// throughput: one request per cycle; every stage advances together while the
// output register is empty or being taken, and the whole pipe holds otherwise
// the 31-stage divider, 16 log2 stages and 16 exp2 stages set the depth
// reset: valid bits clear, the light scale register returns to 100.0 (Q7.8 25600)
module light_diameter_shading_factor_top
	import ldsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] light_scale,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [14:0] light_level,
	input  logic [14:0] compensation_point,
	input  logic [15:0] light_exponent,
	input  logic [15:0] diameter_rate,
	input  logic [15:0] diameter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] shading_factor
);

	`include "light_diameter_shading_factor_top_defines.svh"

	logic        adv;
	logic [14:0] scale_q;

	// stage 1
	logic        v_s1;
	logic [14:0] d_s1;
	logic [14:0] s_s1;
	div_side_t   side_s1;

	// divider output
	logic        div_v;
	logic [30:0] div_x;
	div_side_t   div_side;

	// stage 2
	logic        v_s2;
	logic [30:0] x_s2;
	logic [4:0]  p_s2;
	logic        z_s2;
	logic [15:0] a_s2;
	logic [26:0] u_s2;
	logic [4:0]  lz;
	logic [62:0] u_full;

	// stage 3
	logic        v_s3;
	logic [30:0] m_s3;
	log_side_t   side_s3;
	logic [15:0] fd_s3;

	// log2 output and fd delay
	logic        log_v;
	logic [15:0] log_fr;
	log_side_t   log_side;
	logic [15:0] fd_d_s [LOG_STAGES];

	// stage 4
	logic        v_s4;
	logic signed [38:0] y_s4;
	log_side_t   side_s4;
	logic [15:0] fd_s4;
	logic signed [21:0] l2;

	// stage 5
	logic        v_s5;
	logic [15:0] f_s5;
	logic [15:0] fd_s5;
	pow_side_t   side_s5;

	// exp2 output
	logic        pow_v;
	logic [30:0] pow_m0;
	logic [30:0] pow_m1;
	pow_side_t   pow_side;

	// stage 6
	logic        v_s6;
	logic [39:0] p_s6;
	logic [24:0] fac_s6;
	logic [39:0] pw;
	logic [24:0] fac;
	logic signed [11:0] shl;
	logic [11:0] rsh;
	logic [11:0] esh;
	logic [31:0] mant_e;
	logic [31:0] e_val;

	// stage 7
	logic        v_s7;
	logic [44:0] hi_s7;
	logic [44:0] lo_s7;
	logic [39:0] p_s7;

	// stage 8
	logic        v_s8;
	logic [15:0] res_s8;
	logic [65:0] sum;
	logic [40:0] res_w;

	assign adv       = !v_s8 || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// light scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid) begin
			scale_q <= light_scale;
		end
	end

	// valid bits of the glue stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= div_v;
			v_s3 <= v_s2;
			v_s4 <= log_v;
			v_s5 <= v_s4;
			v_s6 <= pow_v;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// light above compensation, nonzero scale, rate times diameter
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1      <= (light_level > compensation_point) ?
				15'(light_level - compensation_point) : '0;
			s_s1      <= (scale_q != '0) ? scale_q : 15'd1;
			side_s1.a <= light_exponent;
			side_s1.t <= {16'b0, diameter_rate} * {16'b0, diameter};
		end
	end

	ldsf_div #(
		.SIDE_W(DIV_SIDE_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_v    (v_s1),
		.num     (d_s1),
		.den     (s_s1),
		.side_in (side_s1),
		.out_v   (div_v),
		.quo     (div_x),
		.side_out(div_side)
	);

	// leading one of the base
	always_comb begin
		lz = '0;
		for (int i = 0; i < 31; i++) begin
			if (div_x[i]) begin
				lz = 5'(i);
			end
		end
	end

	assign u_full = {31'b0, div_side.t} * {32'b0, LOG2E_Q30};

	// stage 2: msb position and scaled exponent of e
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= div_x;
			p_s2 <= lz;
			z_s2 <= (div_x == '0);
			a_s2 <= div_side.a;
			u_s2 <= u_full[62:36];
		end
	end

	// stage 3: normalize base to Q30, split the e exponent
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3       <= 31'(x_s2 << (5'd30 - p_s2));
			side_s3.a  <= a_s2;
			side_s3.p  <= p_s2;
			side_s3.z  <= z_s2;
			side_s3.n  <= u_s2[26:16];
			side_s3.fz <= (u_s2[15:0] == '0);
			fd_s3      <= 16'(17'h1_0000 - {1'b0, u_s2[15:0]});
		end
	end

	ldsf_log2 #(
		.SIDE_W(LOG_SIDE_W)
	) u_log2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_v    (v_s3),
		.mant    (m_s3),
		.side_in (side_s3),
		.out_v   (log_v),
		.frac    (log_fr),
		.side_out(log_side)
	);

	// delay line for the e fraction beside the log2 stages
	for (genvar k = 0; k < LOG_STAGES; k++) begin : g_fd
		always_ff @(posedge clk) begin
			if (adv) begin
				if (k == 0) begin
					fd_d_s[k] <= fd_s3;
				end else begin
					fd_d_s[k] <= fd_d_s[k == 0 ? 0 : k-1];
				end
			end
		end
	end

	assign l2 = {6'(7'({2'b0, log_side.p}) - 7'd16), log_fr};

	// stage 4: exponent times log2 of base
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s4    <= 39'(l2 * $signed({1'b0, log_side.a}));
			side_s4 <= log_side;
			fd_s4   <= fd_d_s[LOG_STAGES-1];
		end
	end

	// stage 5: integer and fraction of the power exponent
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5        <= y_s4[27:12];
			fd_s5       <= fd_s4;
			side_s5.nn  <= y_s4[38:28];
			side_s5.z   <= side_s4.z;
			side_s5.a0  <= (side_s4.a == '0);
			side_s5.n   <= side_s4.n;
			side_s5.fz  <= side_s4.fz;
		end
	end

	ldsf_pow2 #(
		.SIDE_W(POW_SIDE_W)
	) u_pow2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_v    (v_s5),
		.f0      (f_s5),
		.f1      (fd_s5),
		.side_in (side_s5),
		.out_v   (pow_v),
		.m0      (pow_m0),
		.m1      (pow_m1),
		.side_out(pow_side)
	);

	// power in Q16 with saturation, diameter factor in Q24
	always_comb begin
		shl = 12'($signed(pow_side.nn)) - 12'sd14;
		rsh = 12'(-shl);
		if (pow_side.z) begin
			pw = pow_side.a0 ? 40'h1_0000 : '0;
		end else if ($signed(pow_side.nn) >= 11'sd23) begin
			pw = POW_SAT;
		end else if (shl >= 12'sd0) begin
			pw = {9'b0, pow_m0} << shl[3:0];
		end else if (rsh > 12'd30) begin
			pw = '0;
		end else begin
			pw = {9'b0, pow_m0 >> rsh[4:0]};
		end
		if (pw > POW_SAT) begin
			pw = POW_SAT;
		end
		mant_e = pow_side.fz ? 32'h8000_0000 : {1'b0, pow_m1};
		esh    = 12'({1'b0, pow_side.n} + 12'd7);
		e_val  = (esh >= 12'd32) ? '0 : (mant_e >> esh[4:0]);
		fac    = ONE_Q24 - e_val[24:0];
	end

	// stage 6
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6   <= pw;
			fac_s6 <= fac;
		end
	end

	// stage 7: split product into two partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s7 <= {25'b0, p_s6[39:20]} * {20'b0, fac_s6};
			lo_s7 <= {25'b0, p_s6[19:0]} * {20'b0, fac_s6};
			p_s7  <= p_s6;
		end
	end

	// round half up to Q15 and clamp at one
	assign sum   = ({21'b0, hi_s7} << 20) + {21'b0, lo_s7} + 66'h100_0000;
	assign res_w = sum[65:25];

	// stage 8: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s8 <= (res_w > {25'b0, RESULT_ONE}) ? RESULT_ONE : res_w[15:0];
		end
	end

	assign out_valid      = v_s8;
	assign shading_factor = res_s8;

	// checks on the pipeline
	`LDSF_ASSERT_NOW(a_res_range, out_valid, shading_factor <= RESULT_ONE)
	`LDSF_ASSERT_NOW(a_pow_sat, v_s7, p_s7 <= POW_SAT)
	`LDSF_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, $stable(v_s1) && $stable(v_s7))

endmodule
